// ===== sv/ctl_pkg.sv =====
// Shared types, constants and mode table for the cue track layout block.
`default_nettype none
package ctl_pkg;

    localparam int MAX_TRACKS     = 99;
    localparam int FILE_SIZE_BITS = 48;
    localparam int IDX_W          = 19;
    localparam int BASE_W         = 50;
    localparam int GAP_W          = 28;
    localparam int TRACK_W        = 7;
    localparam int DIV_CNT_W      = $clog2(FILE_SIZE_BITS);

    localparam logic [3:0] MODE_AUDIO      = 4'd0;
    localparam logic [3:0] MODE_CDG        = 4'd1;
    localparam logic [3:0] MODE_M1_2048    = 4'd2;
    localparam logic [3:0] MODE_M1_2352    = 4'd3;
    localparam logic [3:0] MODE_M1_2448    = 4'd4;
    localparam logic [3:0] MODE_M2_2048    = 4'd5;
    localparam logic [3:0] MODE_M2_2324    = 4'd6;
    localparam logic [3:0] MODE_M2_2336    = 4'd7;
    localparam logic [3:0] MODE_M2_2352    = 4'd8;
    localparam logic [3:0] MODE_M2_2448    = 4'd9;
    localparam logic [3:0] MODE_CDI_2336   = 4'd10;
    localparam logic [3:0] MODE_CDI_2352   = 4'd11;

    localparam logic [1:0] KIND_AUDIO = 2'd0;
    localparam logic [1:0] KIND_MODE1 = 2'd1;
    localparam logic [1:0] KIND_MODE2 = 2'd2;

    typedef struct packed {
        logic                      new_file;
        logic [FILE_SIZE_BITS-1:0] file_size_bytes;
        logic [IDX_W-1:0]          index0_sector;
        logic                      has_index0;
        logic [IDX_W-1:0]          index1_sector;
        logic [IDX_W-1:0]          pregap_sectors;
        logic [IDX_W-1:0]          postgap_sectors;
        logic                      last_entry;
        logic [11:0]               sector_bytes;
        logic [4:0]                user_offset;
        logic [1:0]                track_kind;
    } t_cmd;

    typedef struct packed {
        logic [31:0]        first_sector;
        logic [31:0]        sector_count;
        logic [11:0]        sector_bytes;
        logic [4:0]         user_offset;
        logic [1:0]         track_kind;
        logic [30:0]        source_offset;
        logic [TRACK_W-1:0] file_number;
        logic               overflow;
        logic               last_track;
    } t_result;

    function automatic logic [11:0] mode_size(input logic [3:0] code);
        logic [11:0] s;
        case (code)
            MODE_CDG:      s = 12'd2448;
            MODE_M1_2048:  s = 12'd2048;
            MODE_M1_2448:  s = 12'd2448;
            MODE_M2_2048:  s = 12'd2048;
            MODE_M2_2324:  s = 12'd2324;
            MODE_M2_2336:  s = 12'd2336;
            MODE_M2_2448:  s = 12'd2448;
            MODE_CDI_2336: s = 12'd2336;
            default:       s = 12'd2352;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] mode_offset(input logic [3:0] code);
        logic [4:0] o;
        case (code)
            MODE_M1_2352, MODE_M1_2448:                 o = 5'd16;
            MODE_M2_2336, MODE_CDI_2336:                o = 5'd8;
            MODE_M2_2352, MODE_M2_2448, MODE_CDI_2352:  o = 5'd24;
            default:                                    o = 5'd0;
        endcase
        return o;
    endfunction

    function automatic logic [1:0] mode_kind(input logic [3:0] code);
        logic [1:0] k;
        case (code)
            MODE_M1_2048, MODE_M1_2352, MODE_M1_2448: k = KIND_MODE1;
            MODE_M2_2048, MODE_M2_2324, MODE_M2_2336, MODE_M2_2352,
            MODE_M2_2448, MODE_CDI_2336, MODE_CDI_2352: k = KIND_MODE2;
            default: k = KIND_AUDIO;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== sv/ctl_item_if.sv =====
// Input channel carrying one parsed cue-sheet track entry per transfer.
`default_nettype none
interface ctl_item_if;
    logic                               valid;
    logic                               ready;
    logic                               new_file;
    logic [ctl_pkg::FILE_SIZE_BITS-1:0] file_size_bytes;
    logic [3:0]                         mode_code;
    logic [ctl_pkg::IDX_W-1:0]          index0_sector;
    logic                               has_index0;
    logic [ctl_pkg::IDX_W-1:0]          index1_sector;
    logic [ctl_pkg::IDX_W-1:0]          pregap_sectors;
    logic [ctl_pkg::IDX_W-1:0]          postgap_sectors;
    logic                               last_entry;

    modport source (
        output valid, new_file, file_size_bytes, mode_code, index0_sector, has_index0,
               index1_sector, pregap_sectors, postgap_sectors, last_entry,
        input  ready
    );
    modport sink (
        input  valid, new_file, file_size_bytes, mode_code, index0_sector, has_index0,
               index1_sector, pregap_sectors, postgap_sectors, last_entry,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/ctl_result_if.sv =====
// Output channel carrying one absolute disc track per transfer.
`default_nettype none
interface ctl_result_if;
    logic                        valid;
    logic                        ready;
    logic [31:0]                 first_sector;
    logic [31:0]                 sector_count;
    logic [11:0]                 sector_bytes;
    logic [4:0]                  user_offset;
    logic [1:0]                  track_kind;
    logic [30:0]                 source_offset;
    logic [ctl_pkg::TRACK_W-1:0] file_number;
    logic                        overflow;
    logic                        last_track;

    modport source (
        output valid, first_sector, sector_count, sector_bytes, user_offset, track_kind,
               source_offset, file_number, overflow, last_track,
        input  ready
    );
    modport sink (
        input  valid, first_sector, sector_count, sector_bytes, user_offset, track_kind,
               source_offset, file_number, overflow, last_track,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/ctl_front.sv =====
// Front end: accepts entries, decodes the mode and queues commands for the back end.
`default_nettype none
module ctl_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ctl_item_if.sink        i_item,
    output ctl_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid,
    input  wire logic       i_cmd_ready
);

    localparam int QUEUE_DEPTH = 2;

    ctl_pkg::t_cmd r_q [QUEUE_DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    ctl_pkg::t_cmd w_cmd_in;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd_in.new_file        = i_item.new_file;
        w_cmd_in.file_size_bytes = i_item.file_size_bytes;
        w_cmd_in.index0_sector   = i_item.index0_sector;
        w_cmd_in.has_index0      = i_item.has_index0;
        w_cmd_in.index1_sector   = i_item.index1_sector;
        w_cmd_in.pregap_sectors  = i_item.pregap_sectors;
        w_cmd_in.postgap_sectors = i_item.postgap_sectors;
        w_cmd_in.last_entry      = i_item.last_entry;
        w_cmd_in.sector_bytes    = ctl_pkg::mode_size(i_item.mode_code);
        w_cmd_in.user_offset     = ctl_pkg::mode_offset(i_item.mode_code);
        w_cmd_in.track_kind      = ctl_pkg::mode_kind(i_item.mode_code);
    end

    assign i_item.ready = (r_count != 2'(QUEUE_DEPTH));
    assign w_push       = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_count != 2'd0);
    assign w_pop        = o_cmd_valid && i_cmd_ready;
    assign o_cmd        = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/ctl_back.sv =====
// Back end: track layout sequencer with bit-serial sector count divider and result register.
`default_nettype none
module ctl_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ctl_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    ctl_result_if.source        o_res
);

    localparam int FSB = ctl_pkg::FILE_SIZE_BITS;
    localparam int CW  = ctl_pkg::DIV_CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_EMIT_PREV, S_UPDATE, S_START, S_DIV,
        S_EMIT_LAST, S_EMIT_FLUSH, S_EMIT_OVF
    } t_state;

    t_state                          r_state;
    ctl_pkg::t_cmd                   r_cmd;
    logic                            r_pend_valid;
    logic [31:0]                     r_pend_start;
    logic [ctl_pkg::IDX_W-1:0]       r_pend_index1;
    logic [11:0]                     r_pend_size;
    logic [4:0]                      r_pend_offset;
    logic [1:0]                      r_pend_kind;
    logic [FSB-1:0]                  r_pend_sectors;
    logic [ctl_pkg::TRACK_W-1:0]     r_pend_fileno;
    logic [ctl_pkg::BASE_W-1:0]      r_disc_base;
    logic [ctl_pkg::GAP_W-1:0]       r_gap;
    logic [ctl_pkg::TRACK_W-1:0]     r_tracks;
    logic [FSB-1:0]                  r_div_q;
    logic [11:0]                     r_div_rem;
    logic [CW-1:0]                   r_div_cnt;
    ctl_pkg::t_result                r_out;
    logic                            r_out_valid;

    logic                            w_slot_free;
    logic                            w_emit;
    logic                            w_ovf;
    logic [31:0]                     w_end;
    ctl_pkg::t_result                w_pend_res;
    ctl_pkg::t_result                w_ovf_res;
    logic [ctl_pkg::GAP_W:0]         w_gap_pre;
    logic [ctl_pkg::GAP_W:0]         w_gap_post;
    logic [ctl_pkg::GAP_W-1:0]       n_gap_pre;
    logic [ctl_pkg::GAP_W-1:0]       n_gap_post;
    logic signed [ctl_pkg::BASE_W:0] w_start_sum;
    logic [31:0]                     n_start;
    logic [12:0]                     w_trial;
    logic                            w_take;
    logic [11:0]                     n_div_rem;
    logic [FSB-1:0]                  n_div_q;

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_emit      = w_slot_free
                         && (r_state inside {S_EMIT_PREV, S_EMIT_LAST, S_EMIT_FLUSH, S_EMIT_OVF});
    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_ovf       = (r_tracks >= ctl_pkg::TRACK_W'(ctl_pkg::MAX_TRACKS));

    always_comb begin
        if (r_state == S_EMIT_PREV && !r_cmd.new_file) begin
            w_end = r_cmd.has_index0 ? 32'(r_cmd.index0_sector) : 32'(r_cmd.index1_sector);
        end else begin
            w_end = r_pend_sectors[31:0];
        end
        w_pend_res.first_sector  = r_pend_start;
        w_pend_res.sector_count  = (w_end > 32'(r_pend_index1))
                                   ? (w_end - 32'(r_pend_index1)) : 32'd0;
        w_pend_res.sector_bytes  = r_pend_size;
        w_pend_res.user_offset   = r_pend_offset;
        w_pend_res.track_kind    = r_pend_kind;
        w_pend_res.source_offset = 31'(31'(r_pend_index1) * 31'(r_pend_size));
        w_pend_res.file_number   = r_pend_fileno;
        w_pend_res.overflow      = 1'b0;
        w_pend_res.last_track    = (r_state == S_EMIT_LAST);

        w_ovf_res            = '0;
        w_ovf_res.overflow   = 1'b1;
        w_ovf_res.last_track = r_cmd.last_entry;
    end

    always_comb begin
        w_gap_pre  = {1'b0, r_gap} + (ctl_pkg::GAP_W + 1)'(r_cmd.pregap_sectors);
        n_gap_pre  = w_gap_pre[ctl_pkg::GAP_W] ? '1 : w_gap_pre[ctl_pkg::GAP_W-1:0];
        w_gap_post = {1'b0, r_gap} + (ctl_pkg::GAP_W + 1)'(r_cmd.postgap_sectors);
        n_gap_post = w_gap_post[ctl_pkg::GAP_W] ? '1 : w_gap_post[ctl_pkg::GAP_W-1:0];

        w_start_sum = $signed({r_disc_base[ctl_pkg::BASE_W-1], r_disc_base})
                    + $signed((ctl_pkg::BASE_W + 1)'(r_gap))
                    + $signed((ctl_pkg::BASE_W + 1)'(r_cmd.index1_sector));
        n_start     = w_start_sum[ctl_pkg::BASE_W] ? 32'd0 : w_start_sum[31:0];

        w_trial   = {r_div_rem, r_div_q[FSB-1]};
        w_take    = (w_trial >= {1'b0, r_pend_size});
        n_div_rem = w_take ? 12'(w_trial - {1'b0, r_pend_size}) : w_trial[11:0];
        n_div_q   = {r_div_q[FSB-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_tracks     <= '0;
            r_gap        <= '0;
            r_disc_base  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_ovf) begin
                        r_state <= (r_cmd.last_entry && r_pend_valid) ? S_EMIT_FLUSH
                                                                       : S_EMIT_OVF;
                    end else begin
                        r_state <= r_pend_valid ? S_EMIT_PREV : S_UPDATE;
                    end
                end
                S_EMIT_PREV: begin
                    if (w_slot_free) begin
                        r_out   <= w_pend_res;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_tracks == '0) begin
                        r_disc_base   <= ctl_pkg::BASE_W'(0)
                                       - ctl_pkg::BASE_W'(r_cmd.index1_sector);
                        r_pend_fileno <= '0;
                    end else if (r_cmd.new_file) begin
                        r_disc_base   <= r_disc_base + ctl_pkg::BASE_W'(r_pend_sectors);
                        r_pend_fileno <= r_pend_fileno + ctl_pkg::TRACK_W'(1);
                    end
                    r_gap   <= n_gap_pre;
                    r_state <= S_START;
                end
                S_START: begin
                    r_pend_valid  <= 1'b1;
                    r_pend_start  <= n_start;
                    r_pend_index1 <= r_cmd.index1_sector;
                    r_pend_size   <= r_cmd.sector_bytes;
                    r_pend_offset <= r_cmd.user_offset;
                    r_pend_kind   <= r_cmd.track_kind;
                    r_gap         <= n_gap_post;
                    r_tracks      <= r_tracks + ctl_pkg::TRACK_W'(1);
                    r_div_q       <= r_cmd.file_size_bytes;
                    r_div_rem     <= '0;
                    r_div_cnt     <= CW'(FSB - 1);
                    r_state       <= S_DIV;
                end
                S_DIV: begin
                    r_div_q   <= n_div_q;
                    r_div_rem <= n_div_rem;
                    r_div_cnt <= r_div_cnt - CW'(1);
                    if (r_div_cnt == '0) begin
                        r_pend_sectors <= n_div_q;
                        r_state        <= r_cmd.last_entry ? S_EMIT_LAST : S_IDLE;
                    end
                end
                S_EMIT_LAST: begin
                    if (w_slot_free) begin
                        r_out        <= w_pend_res;
                        r_pend_valid <= 1'b0;
                        r_tracks     <= '0;
                        r_gap        <= '0;
                        r_disc_base  <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                S_EMIT_FLUSH: begin
                    if (w_slot_free) begin
                        r_out   <= w_pend_res;
                        r_state <= S_EMIT_OVF;
                    end
                end
                S_EMIT_OVF: begin
                    if (w_slot_free) begin
                        r_out <= w_ovf_res;
                        if (r_cmd.last_entry) begin
                            r_pend_valid <= 1'b0;
                            r_tracks     <= '0;
                            r_gap        <= '0;
                            r_disc_base  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.first_sector  = r_out.first_sector;
    assign o_res.sector_count  = r_out.sector_count;
    assign o_res.sector_bytes  = r_out.sector_bytes;
    assign o_res.user_offset   = r_out.user_offset;
    assign o_res.track_kind    = r_out.track_kind;
    assign o_res.source_offset = r_out.source_offset;
    assign o_res.file_number   = r_out.file_number;
    assign o_res.overflow      = r_out.overflow;
    assign o_res.last_track    = r_out.last_track;

endmodule
`default_nettype wire

// ===== sv/cue_track_layout_top.sv =====
// Top level of the cue track layout block: front end, command queue and back end.
//
//  channel  direction  transfer                 payload
//  i_item   in         i_item.valid & ready     one parsed cue-sheet track entry
//  o_res    out        o_res.valid & ready      one absolute disc track
//
// In the back end an entry passes the check, any emit of the pending previous track,
// the update and start states, 48 bit-serial division steps of the file size by the
// sector size and, for a last entry, an emit of its own track. An entry past the track
// limit is dropped with an overflow result; a waiting result register stalls each emit.
// A two-entry front-end queue keeps accepting, until full, while the back end works.
// Reset is synchronous, active low, and clears all track state, as does a last entry.
`default_nettype none
module cue_track_layout_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ctl_item_if.sink      i_item,
    ctl_result_if.source  o_res
);

    ctl_pkg::t_cmd w_cmd;
    logic          w_cmd_valid;
    logic          w_cmd_ready;

    ctl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    ctl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
